### design/assert_macros.svh
// Assertion macros shared by the absorb table RTL.
// Depends on nothing; files that assert take it by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every edge outside reset
`define WALAT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("walat implication violated");

// implication checked in the cycle after the antecedent
`define WALAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("walat next-cycle check violated");

`endif

### design/walat_pkg.sv
// Types and codes for the write-ahead log absorb table.
// Used by walat_table and write_ahead_log_absorb_table; no dependencies.
package walat_pkg;

  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;
  localparam int FIELD_W  = 32;
  localparam int INDEX_W  = 6;
  localparam int CFG_W    = 7;
  localparam int OPS_W    = 7;
  localparam int PROD_W   = 16;

  localparam logic [OP_W-1:0] OP_BEGIN   = 2'd0;
  localparam logic [OP_W-1:0] OP_END     = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd2;
  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

  localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_WAIT     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ABSORBED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ENDED    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_COMMIT   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE  = 3'd6;
  localparam logic [STATUS_W-1:0] ST_ERROR    = 3'd7;

  localparam logic CFG_LOG_SLOTS = 1'b0;
  localparam logic CFG_MAX_OP    = 1'b1;

  localparam logic [OPS_W-1:0] OPS_MAX = 7'd127;
  localparam logic [CFG_W-1:0] LOG_SLOTS_RST = 7'd30;
  localparam logic [CFG_W-1:0] MAX_OP_RST    = 7'd10;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_BEGIN,
    FSM_END,
    FSM_WRITE,
    FSM_SEARCH,
    FSM_ADD,
    FSM_COMMIT
  } walat_state_e;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } walat_mem_ctl_t;

endpackage

### design/write_ahead_log_absorb_table.sv
// Channel  | signals                                         | beat moves
// input    | in_valid_i/in_ready_o, operation_i, block_num.. | one command
// output   | out_valid_o/out_ready_i, status_o .. last_o     | one result
// config   | cfg_we_i, cfg_index_i, cfg_data_i               | one register write
// A write searches the table with a one-entry-per-cycle scan of the memory read port.
// A commit streams one entry per cycle while the output is not stalled.
// Reset clears open operations and entry count; the table needs no clearing.
// A stalled output holds the block in any step that emits a result; input is taken in idle only.
// Top level of the group-commit absorb table; uses walat_pkg and walat_table.
`include "assert_macros.svh"
module write_ahead_log_absorb_table #(
  parameter int LOG_ENTRIES = 32,
  parameter int BLOCK_BITS  = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_index_i,
  input  logic [walat_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [walat_pkg::OP_W-1:0]          operation_i,
  input  logic [walat_pkg::FIELD_W-1:0]       block_number_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [walat_pkg::STATUS_W-1:0]      status_o,
  output logic [walat_pkg::FIELD_W-1:0]       home_block_o,
  output logic [walat_pkg::INDEX_W-1:0]       entry_index_o,
  output logic                                last_o
);
  import walat_pkg::*;

  localparam int IDX_W = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;
  localparam int CNT_W = $clog2(LOG_ENTRIES + 1);
  localparam logic [CFG_W-1:0] ENTRIES_C = CFG_W'(LOG_ENTRIES);

  walat_state_e state_q, state_d;
  logic [OPS_W-1:0]      open_ops_q, open_ops_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [CFG_W-1:0]      log_slots_q, max_op_q;
  logic [PROD_W-1:0]     prod;
  logic [OP_W-1:0]       op_q;
  logic [BLOCK_BITS-1:0] blk_q;

  logic                  out_valid_q;
  logic [STATUS_W-1:0]   status_q;
  logic [FIELD_W-1:0]    home_q;
  logic [INDEX_W-1:0]    index_q;
  logic                  last_q;

  logic                  can_emit, emit;
  logic [STATUS_W-1:0]   e_status;
  logic [FIELD_W-1:0]    e_home;
  logic [INDEX_W-1:0]    e_index;
  logic                  e_last;
  logic [PROD_W-1:0]     reserved;
  logic                  idx_last;
  logic [CFG_W-1:0]      count_ext;

  walat_mem_ctl_t        mem_ctl;
  logic [IDX_W-1:0]      rd_addr;
  logic [BLOCK_BITS-1:0] rd_data;

  walat_table #(
    .ENTRIES (LOG_ENTRIES),
    .DATA_W  (BLOCK_BITS),
    .ADDR_W  (IDX_W)
  ) u_table (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .wr_addr_i (count_q[IDX_W-1:0]),
    .wr_data_i (blk_q),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign can_emit   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == FSM_IDLE);
  assign count_ext  = CFG_W'(count_q);
  assign prod       = (PROD_W'(open_ops_q) + PROD_W'(1)) * PROD_W'(max_op_q);
  assign reserved   = PROD_W'(count_q) + prod;
  assign idx_last   = (CFG_W'(idx_q) + CFG_W'(1)) == count_ext;

  always_comb begin
    state_d    = state_q;
    open_ops_d = open_ops_q;
    count_d    = count_q;
    idx_d      = idx_q;
    emit       = 1'b0;
    e_status   = ST_ENDED;
    e_home     = '0;
    e_index    = '0;
    e_last     = 1'b1;
    mem_ctl    = '0;
    rd_addr    = '0;
    case (state_q)
      FSM_IDLE: begin
        if (in_valid_i) begin
          case (operation_i)
            OP_BEGIN: state_d = FSM_BEGIN;
            OP_END:   state_d = FSM_END;
            OP_WRITE: state_d = FSM_WRITE;
            default:  state_d = FSM_IDLE;
          endcase
        end
      end
      FSM_BEGIN: begin
        if (can_emit) begin
          emit    = 1'b1;
          state_d = FSM_IDLE;
          if (open_ops_q < OPS_MAX && reserved <= PROD_W'(log_slots_q)) begin
            open_ops_d = open_ops_q + OPS_W'(1);
            e_status   = ST_GRANTED;
          end else begin
            e_status = ST_WAIT;
          end
        end
      end
      FSM_END: begin
        if (open_ops_q == '0) begin
          if (can_emit) begin
            emit     = 1'b1;
            e_status = ST_ERROR;
            state_d  = FSM_IDLE;
          end
        end else if (open_ops_q != OPS_W'(1) || count_q == '0) begin
          if (can_emit) begin
            emit       = 1'b1;
            e_status   = ST_ENDED;
            open_ops_d = open_ops_q - OPS_W'(1);
            state_d    = FSM_IDLE;
          end
        end else begin
          open_ops_d    = '0;
          idx_d         = '0;
          mem_ctl.rd_en = 1'b1;
          rd_addr       = '0;
          state_d       = FSM_COMMIT;
        end
      end
      FSM_COMMIT: begin
        if (can_emit) begin
          emit     = 1'b1;
          e_status = ST_COMMIT;
          e_home   = FIELD_W'(rd_data);
          e_index  = INDEX_W'(idx_q);
          e_last   = idx_last;
          if (idx_last) begin
            count_d = '0;
            state_d = FSM_IDLE;
          end else begin
            idx_d         = idx_q + IDX_W'(1);
            mem_ctl.rd_en = 1'b1;
            rd_addr       = idx_q + IDX_W'(1);
          end
        end
      end
      FSM_WRITE: begin
        if (open_ops_q == '0) begin
          if (can_emit) begin
            emit     = 1'b1;
            e_status = ST_OUTSIDE;
            state_d  = FSM_IDLE;
          end
        end else if (count_q == '0) begin
          state_d = FSM_ADD;
        end else begin
          idx_d         = '0;
          mem_ctl.rd_en = 1'b1;
          rd_addr       = '0;
          state_d       = FSM_SEARCH;
        end
      end
      FSM_SEARCH: begin
        if (rd_data == blk_q) begin
          if (can_emit) begin
            emit     = 1'b1;
            e_status = ST_ABSORBED;
            e_home   = FIELD_W'(blk_q);
            e_index  = INDEX_W'(idx_q);
            state_d  = FSM_IDLE;
          end
        end else if (idx_last) begin
          state_d = FSM_ADD;
        end else begin
          idx_d         = idx_q + IDX_W'(1);
          mem_ctl.rd_en = 1'b1;
          rd_addr       = idx_q + IDX_W'(1);
        end
      end
      FSM_ADD: begin
        if (can_emit) begin
          emit    = 1'b1;
          state_d = FSM_IDLE;
          if (count_ext >= log_slots_q || count_ext >= ENTRIES_C) begin
            e_status = ST_ERROR;
          end else begin
            mem_ctl.wr_en = 1'b1;
            e_status      = ST_APPENDED;
            e_home        = FIELD_W'(blk_q);
            e_index       = INDEX_W'(count_q);
            count_d       = count_q + CNT_W'(1);
          end
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      open_ops_q  <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      log_slots_q <= LOG_SLOTS_RST;
      max_op_q    <= MAX_OP_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      open_ops_q <= open_ops_d;
      count_q    <= count_d;
      idx_q      <= idx_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_LOG_SLOTS: log_slots_q <= cfg_data_i;
          CFG_MAX_OP:    max_op_q    <= cfg_data_i;
          default:       log_slots_q <= log_slots_q;
        endcase
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q  <= operation_i;
      blk_q <= block_number_i[BLOCK_BITS-1:0];
    end
    if (emit) begin
      status_q <= e_status;
      home_q   <= e_home;
      index_q  <= e_index;
      last_q   <= e_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign home_block_o  = home_q;
  assign entry_index_o = index_q;
  assign last_o        = last_q;

  `WALAT_ASSERT_IMPLY(a_count_bound, clk_i, rst_ni, 1'b1, count_ext <= ENTRIES_C)
  `WALAT_ASSERT_IMPLY(a_write_room, clk_i, rst_ni, mem_ctl.wr_en, count_ext < ENTRIES_C)
  `WALAT_ASSERT_IMPLY(a_search_open, clk_i, rst_ni, state_q == FSM_SEARCH, open_ops_q != '0)
  `WALAT_ASSERT_NEXT(a_commit_clears, clk_i, rst_ni,
    emit && e_status == ST_COMMIT && e_last, count_q == '0 && open_ops_q == '0)
  `WALAT_ASSERT_IMPLY(a_op_latched, clk_i, rst_ni,
    state_q == FSM_WRITE, op_q == OP_WRITE)

endmodule

### design/walat_table.sv
// Block number table: one write port, one read port, registered read data.
// Depends on walat_pkg for the memory control struct.
module walat_table #(
  parameter int ENTRIES = 32,
  parameter int DATA_W  = 32,
  parameter int ADDR_W  = 5
) (
  input  logic                       clk_i,
  input  walat_pkg::walat_mem_ctl_t  ctl_i,
  input  logic [ADDR_W-1:0]          wr_addr_i,
  input  logic [DATA_W-1:0]          wr_data_i,
  input  logic [ADDR_W-1:0]          rd_addr_i,
  output logic [DATA_W-1:0]          rd_data_o
);
  import walat_pkg::*;

  logic [DATA_W-1:0] mem [ENTRIES];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
